/* design/sdcmd_pkg.sv */
// Package for the SD-card SPI-mode command engine: transaction payload types,
// bus action codes, state encodings and the CRC7 byte-update function.
// No dependencies.
`default_nettype none

package sdcmd_pkg;

    // Bus action codes carried in a result transaction
    localparam logic [2:0] ACT_SELECT   = 3'd0;
    localparam logic [2:0] ACT_SEND     = 3'd1;
    localparam logic [2:0] ACT_READ     = 3'd2;
    localparam logic [2:0] ACT_DESELECT = 3'd3;
    localparam logic [2:0] ACT_DONE     = 3'd4;

    // Input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_RX    = 1'b1;

    // Frame and bus constants
    localparam logic [1:0] FRAME_START_BITS = 2'b01;
    localparam logic [7:0] CRC7_POLY        = 8'h12;
    localparam logic [7:0] IDLE_BYTE        = 8'hff;
    localparam logic [7:0] POLL_LIMIT_RST   = 8'd100;

    // Register map: byte address bit 2 selects the register (only index 0 exists)
    localparam int         PADDR_W       = 3;
    localparam logic       REG_POLL_LIMIT = 1'b0;

    // Sequencer step numbers
    localparam logic [4:0] STEP_START_LAST = 5'd7;
    localparam logic [4:0] STEP_CRC        = 5'd6;

    typedef struct packed {
        logic        kind;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic [3:0]  trail_count;
        logic        extra_read;
        logic        release_after;
        logic        skip_first;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] bus_byte;
        logic [7:0] response;
        logic [7:0] extra_byte;
        logic       status;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SKIP  = 4'b0010,
        PH_POLL  = 4'b0100,
        PH_EXTRA = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        SQ_START  = 3'b001,
        SQ_READ   = 3'b010,
        SQ_FINISH = 3'b100
    } t_seq_kind;

    // Fold one frame byte into the running CRC7 (kept shifted left by one)
    function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int j = 0; j < 8; j++) begin
            c = {c[6:0], 1'b0} ^ (c[7] ? CRC7_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/sd_spi_command_engine_top.sv */
// SD-card SPI-mode command engine: command/poll state, result sequencer,
// output register and APB-style poll-limit register.
// Depends on sdcmd_pkg.
//
// Each input transaction updates the command state in the cycle it is taken
// and loads a short result programme into the sequencer, which emits one bus
// action per cycle into the output register while that register is empty or
// being drained. A start yields 8 results, a received byte 0, 1 or between 1
// and 18 (trailer bytes, optional deselect, then done). The next transaction
// is taken in the cycle the sequencer emits the last result of the previous
// one, so the single result sequencer sets the rate. The CRC7 of the frame is
// accumulated one byte per emitted frame byte. Received bytes while idle are
// accepted and dropped; a start taken while a command is still in progress
// abandons that command. poll_limit (index 0, reset 100) sits at byte address 0.
`default_nettype none

module sd_spi_command_engine_top
    import sdcmd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input transaction channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_data,
    // result transaction channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_data,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // command state
    t_phase     r_phase, n_phase;
    logic [7:0] r_poll_count, n_poll_count;
    logic [7:0] r_saved_resp, n_saved_resp;
    logic [3:0] r_pend_trail, n_pend_trail;
    logic       r_rel_flag, n_rel_flag;
    logic       r_extra_flag, n_extra_flag;
    logic [7:0] r_poll_limit;

    // sequencer
    logic       r_seq_busy, n_seq_busy;
    t_seq_kind  r_seq_kind, n_seq_kind;
    logic [4:0] r_seq_step, n_seq_step;
    logic [5:0] r_seq_cmd, n_seq_cmd;
    logic [31:0] r_seq_arg, n_seq_arg;
    logic [3:0] r_seq_trail, n_seq_trail;
    logic       r_seq_rel, n_seq_rel;
    logic       r_seq_status, n_seq_status;
    logic [7:0] r_seq_resp, n_seq_resp;
    logic [7:0] r_seq_extra, n_seq_extra;
    logic [7:0] r_crc, n_crc;

    // output register
    logic       r_out_valid;
    t_out_item  r_out_data, w_item;

    logic       w_in_fire, w_emit, w_seq_last, w_load, w_cfg_wr, w_poll_tmo;
    logic [4:0] w_last_step, w_tail_step;
    logic [7:0] w_frame_byte, w_cnt_inc;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POLL_LIMIT);
    assign prdata   = (paddr[2] == REG_POLL_LIMIT) ? {24'd0, r_poll_limit} : 32'd0;

    // handshakes
    assign w_emit     = r_seq_busy && (!r_out_valid || i_out_ready);
    assign w_seq_last = (r_seq_step == w_last_step);
    assign o_in_ready = !r_seq_busy || (w_emit && w_seq_last);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // last step of the loaded programme
    always_comb begin
        case (r_seq_kind)
            SQ_START:  w_last_step = STEP_START_LAST;
            SQ_READ:   w_last_step = 5'd0;
            SQ_FINISH: w_last_step = {1'b0, r_seq_trail} + (r_seq_rel ? 5'd2 : 5'd0);
            default:   w_last_step = 5'd0;
        endcase
    end

    // frame byte for start steps one to five
    always_comb begin
        case (r_seq_step)
            5'd1:    w_frame_byte = {FRAME_START_BITS, r_seq_cmd};
            5'd2:    w_frame_byte = r_seq_arg[31:24];
            5'd3:    w_frame_byte = r_seq_arg[23:16];
            5'd4:    w_frame_byte = r_seq_arg[15:8];
            5'd5:    w_frame_byte = r_seq_arg[7:0];
            default: w_frame_byte = 8'h00;
        endcase
    end

    // result for the current sequencer step
    assign w_tail_step = r_seq_step - {1'b0, r_seq_trail};
    always_comb begin
        w_item        = '0;
        w_item.last   = w_seq_last;
        case (r_seq_kind)
            SQ_START: begin
                if (r_seq_step == 5'd0) begin
                    w_item.action = ACT_SELECT;
                end else if (r_seq_step == STEP_START_LAST) begin
                    w_item.action   = ACT_READ;
                    w_item.bus_byte = IDLE_BYTE;
                end else if (r_seq_step == STEP_CRC) begin
                    w_item.action   = ACT_SEND;
                    w_item.bus_byte = r_crc | 8'h01;
                end else begin
                    w_item.action   = ACT_SEND;
                    w_item.bus_byte = w_frame_byte;
                end
            end
            SQ_READ: begin
                w_item.action   = ACT_READ;
                w_item.bus_byte = IDLE_BYTE;
            end
            SQ_FINISH: begin
                if (r_seq_step < {1'b0, r_seq_trail}) begin
                    w_item.action   = ACT_SEND;
                    w_item.bus_byte = IDLE_BYTE;
                end else if (r_seq_rel && w_tail_step == 5'd0) begin
                    w_item.action = ACT_DESELECT;
                end else if (r_seq_rel && w_tail_step == 5'd1) begin
                    w_item.action   = ACT_SEND;
                    w_item.bus_byte = IDLE_BYTE;
                end else begin
                    w_item.action     = ACT_DONE;
                    w_item.response   = r_seq_resp;
                    w_item.extra_byte = r_seq_extra;
                    w_item.status     = r_seq_status;
                end
            end
            default: w_item = '0;
        endcase
    end

    // command state update and programme selection for an accepted item
    assign w_cnt_inc  = r_poll_count + 8'd1;
    assign w_poll_tmo = (w_cnt_inc >= r_poll_limit);
    always_comb begin
        n_phase      = r_phase;
        n_poll_count = r_poll_count;
        n_saved_resp = r_saved_resp;
        n_pend_trail = r_pend_trail;
        n_rel_flag   = r_rel_flag;
        n_extra_flag = r_extra_flag;
        w_load       = 1'b0;
        n_seq_kind   = r_seq_kind;
        n_seq_cmd    = r_seq_cmd;
        n_seq_arg    = r_seq_arg;
        n_seq_trail  = r_seq_trail;
        n_seq_rel    = r_seq_rel;
        n_seq_status = r_seq_status;
        n_seq_resp   = r_seq_resp;
        n_seq_extra  = r_seq_extra;
        if (w_in_fire) begin
            if (i_in_data.kind == KIND_START) begin
                n_pend_trail = i_in_data.trail_count;
                n_extra_flag = i_in_data.extra_read;
                n_rel_flag   = i_in_data.release_after;
                n_poll_count = 8'd0;
                n_saved_resp = 8'd0;
                n_phase      = i_in_data.skip_first ? PH_SKIP : PH_POLL;
                w_load       = 1'b1;
                n_seq_kind   = SQ_START;
                n_seq_cmd    = i_in_data.cmd_index;
                n_seq_arg    = i_in_data.argument;
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        n_phase    = PH_POLL;
                        w_load     = 1'b1;
                        n_seq_kind = SQ_READ;
                    end
                    PH_POLL: begin
                        n_poll_count = w_cnt_inc;
                        w_load       = 1'b1;
                        if (!i_in_data.rx_byte[7]) begin
                            n_saved_resp = i_in_data.rx_byte;
                            if (r_extra_flag) begin
                                n_phase    = PH_EXTRA;
                                n_seq_kind = SQ_READ;
                            end else begin
                                n_phase      = PH_IDLE;
                                n_seq_kind   = SQ_FINISH;
                                n_seq_trail  = r_pend_trail;
                                n_seq_rel    = r_rel_flag;
                                n_seq_status = 1'b0;
                                n_seq_resp   = i_in_data.rx_byte;
                                n_seq_extra  = 8'd0;
                            end
                        end else if (w_poll_tmo) begin
                            // timeout: deselect, one idle byte, done with status set
                            n_phase      = PH_IDLE;
                            n_seq_kind   = SQ_FINISH;
                            n_seq_trail  = 4'd0;
                            n_seq_rel    = 1'b1;
                            n_seq_status = 1'b1;
                            n_seq_resp   = 8'd0;
                            n_seq_extra  = 8'd0;
                        end else begin
                            n_seq_kind = SQ_READ;
                        end
                    end
                    PH_EXTRA: begin
                        n_phase      = PH_IDLE;
                        w_load       = 1'b1;
                        n_seq_kind   = SQ_FINISH;
                        n_seq_trail  = r_pend_trail;
                        n_seq_rel    = r_rel_flag;
                        n_seq_status = 1'b0;
                        n_seq_resp   = r_saved_resp;
                        n_seq_extra  = i_in_data.rx_byte;
                    end
                    default: begin
                        // byte while idle: dropped
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // sequencer control
    always_comb begin
        n_seq_busy = r_seq_busy;
        n_seq_step = r_seq_step;
        if (w_emit) begin
            n_seq_step = r_seq_step + 5'd1;
            if (w_seq_last) begin
                n_seq_busy = 1'b0;
            end
        end
        if (w_load) begin
            n_seq_busy = 1'b1;
            n_seq_step = 5'd0;
        end
    end

    // CRC7 accumulates as each frame byte goes out
    always_comb begin
        n_crc = r_crc;
        if (w_emit && r_seq_kind == SQ_START) begin
            if (r_seq_step == 5'd0) begin
                n_crc = 8'h00;
            end else if (r_seq_step inside {[5'd1:5'd5]}) begin
                n_crc = crc7_byte(r_crc, w_frame_byte);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_poll_count <= 8'd0;
            r_saved_resp <= 8'd0;
            r_pend_trail <= 4'd0;
            r_rel_flag   <= 1'b0;
            r_extra_flag <= 1'b0;
            r_poll_limit <= POLL_LIMIT_RST;
            r_seq_busy   <= 1'b0;
            r_seq_kind   <= SQ_READ;
            r_seq_step   <= 5'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_poll_count <= n_poll_count;
            r_saved_resp <= n_saved_resp;
            r_pend_trail <= n_pend_trail;
            r_rel_flag   <= n_rel_flag;
            r_extra_flag <= n_extra_flag;
            if (w_cfg_wr) begin
                r_poll_limit <= pwdata[7:0];
            end
            r_seq_busy   <= n_seq_busy;
            r_seq_kind   <= n_seq_kind;
            r_seq_step   <= n_seq_step;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_seq_cmd    <= n_seq_cmd;
        r_seq_arg    <= n_seq_arg;
        r_seq_trail  <= n_seq_trail;
        r_seq_rel    <= n_seq_rel;
        r_seq_status <= n_seq_status;
        r_seq_resp   <= n_seq_resp;
        r_seq_extra  <= n_seq_extra;
        r_crc        <= n_crc;
        if (w_emit) begin
            r_out_data <= w_item;
        end
    end

    // a done result always closes its item, and closing results are reads or done
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.action == ACT_DONE) |-> r_out_data.last)
        else $error("done result without last");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.last) |->
        (r_out_data.action == ACT_DONE || r_out_data.action == ACT_READ))
        else $error("last result is neither read nor done");

    // a start always opens with the select step
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in_data.kind == KIND_START) |=>
        (r_seq_busy && r_seq_kind == SQ_START && r_seq_step == 5'd0))
        else $error("start did not load the sequencer");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_busy |-> (r_seq_step <= w_last_step))
        else $error("sequencer step ran past its programme");

    a_timeout_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.action == ACT_DONE && r_out_data.status) |->
        (r_out_data.response == 8'd0 && r_out_data.extra_byte == 8'd0))
        else $error("timeout result carries response data");

endmodule

`default_nettype wire
